// ===== sv/popq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Priority-ordered process queue package
// Shared types, request modes and sequencer states for the queue.
// ----------------------------------------------------------------------------
package popq_pkg;

   localparam int DEFAULT_QUEUE_DEPTH = 32;

   localparam logic [1:0] MODE_INSERT = 2'd0;
   localparam logic [1:0] MODE_REMOVE = 2'd1;
   localparam logic [1:0] MODE_LOOKUP = 2'd2;

   typedef struct packed {
      logic [1:0]  mode;
      logic [15:0] item_pid;
      logic [7:0]  item_priority;
   } req_type;

   typedef struct packed {
      logic        found;
      logic [15:0] removed_pid;
      logic [7:0]  removed_priority;
      logic        overflow;
      logic        queue_empty;
      logic [15:0] head_pid;
      logic [7:0]  head_priority;
      logic [5:0]  fill_count;
   } rsp_type;

   typedef struct packed {
      logic [15:0] pid;
      logic [7:0]  priority_num;
   } entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INS_STEP,
      ST_INS_EVAL,
      ST_SCAN_STEP,
      ST_SCAN_EVAL,
      ST_HEAD_RD,
      ST_HEAD_EVAL,
      ST_DONE
   } seq_state_type;

endpackage

// ===== sv/priority_ordered_process_queue_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Priority-ordered process queue
// Sorted queue of (process id, priority) entries with insert, remove by id
// and lookup; every request returns one response.
// ----------------------------------------------------------------------------
// Usage:
//   A request on req_data (mode, item_pid, item_priority) is taken when
//   req_valid is high and req_stall is low. Inserts go after every entry
//   whose priority number is less than or equal to their own; a full queue
//   drops the insert and flags overflow. Removes take the first entry with
//   a matching id, lookups only report whether the id is present.
//   Each request returns one response on rsp_data, qualified by rsp_valid,
//   carrying the head (minimum) entry and the fill count after the request.
//   Entries live in a single-port-read memory, and the sequencer visits
//   each entry by first addressing it, then comparing the read data.
//   req_stall stays high while a request is being worked on, until the
//   sequencer is back in idle.
//   The response sits in an output register; the next request may already
//   be worked on while a response is stalled, but it only completes once
//   that response has been taken. Synchronous reset empties the queue at
//   once; the memory contents are not cleared and need not be.
// ----------------------------------------------------------------------------
module priority_ordered_process_queue_top
   import popq_pkg::*;
#(
   parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

   logic          busy;
   logic          done;
   logic          out_free;
   rsp_type       result;
   logic          mem_rd_en;
   logic [AW-1:0] mem_rd_addr;
   entry_type     mem_rd_data;
   logic          mem_wr_en;
   logic [AW-1:0] mem_wr_addr;
   entry_type     mem_wr_data;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   // The response slot frees up when it is empty or being taken this cycle.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = busy;

   popq_seq #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_data    (req_data),
      .out_free    (out_free),
      .busy        (busy),
      .done        (done),
      .result      (result),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data)
   );

   popq_mem #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_mem (
      .clock   (clock),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data)
   );

   // Output register: loads when the sequencer finishes, holds while stalled.
   always_comb begin
      rsp_data_in  = done ? result : rsp_data_ff;
      rsp_valid_in = done || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== sv/popq_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Queue entry memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module popq_mem
   import popq_pkg::*;
#(
   parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH,
   localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1
) (
   input  logic          clock,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output entry_type     rd_data,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  entry_type     wr_data
);

   entry_type mem_ff [QUEUE_DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/popq_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Queue sequencer
// Walks the entry memory one entry at a time to insert, remove or find.
// ----------------------------------------------------------------------------
module popq_seq
   import popq_pkg::*;
#(
   parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH,
   localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
   localparam int CW = AW + 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  req_type       req_data,
   input  logic          out_free,
   output logic          busy,
   output logic          done,
   output rsp_type       result,
   output logic          mem_rd_en,
   output logic [AW-1:0] mem_rd_addr,
   input  entry_type     mem_rd_data,
   output logic          mem_wr_en,
   output logic [AW-1:0] mem_wr_addr,
   output entry_type     mem_wr_data
);

   seq_state_type state_ff, state_in;
   logic [1:0]    mode_ff, mode_in;
   entry_type     item_ff, item_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [CW-1:0] count_ff, count_in;
   logic          hit_ff, hit_in;
   logic          ovf_ff, ovf_in;
   entry_type     removed_ff, removed_in;
   entry_type     head_ff, head_in;
   logic [CW-1:0] idx_dec;

   assign idx_dec = idx_ff - CW'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff    <= mode_in;
      item_ff    <= item_in;
      idx_ff     <= idx_in;
      hit_ff     <= hit_in;
      ovf_ff     <= ovf_in;
      removed_ff <= removed_in;
      head_ff    <= head_in;
   end

   always_comb begin
      state_in    = state_ff;
      mode_in     = mode_ff;
      item_in     = item_ff;
      idx_in      = idx_ff;
      count_in    = count_ff;
      hit_in      = hit_ff;
      ovf_in      = ovf_ff;
      removed_in  = removed_ff;
      head_in     = head_ff;
      mem_rd_en   = 1'b0;
      mem_rd_addr = '0;
      mem_wr_en   = 1'b0;
      mem_wr_addr = idx_ff[AW-1:0];
      mem_wr_data = item_ff;
      done        = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               mode_in    = req_data.mode;
               item_in    = '{pid: req_data.item_pid, priority_num: req_data.item_priority};
               hit_in     = 1'b0;
               ovf_in     = 1'b0;
               removed_in = '0;
               priority if (req_data.mode == MODE_INSERT) begin
                  idx_in = count_ff;
                  if (count_ff >= CW'(QUEUE_DEPTH)) begin
                     ovf_in   = 1'b1;
                     state_in = ST_HEAD_RD;
                  end else begin
                     state_in = ST_INS_STEP;
                  end
               end else if (req_data.mode == MODE_REMOVE ||
                            req_data.mode == MODE_LOOKUP) begin
                  idx_in   = '0;
                  state_in = ST_SCAN_STEP;
               end else begin
                  state_in = ST_HEAD_RD;
               end
            end
         end

         // Walk down from the tail, moving larger entries up one slot.
         ST_INS_STEP: begin
            if (idx_ff == '0) begin
               mem_wr_en = 1'b1;
               count_in  = count_ff + CW'(1);
               state_in  = ST_HEAD_RD;
            end else begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = idx_dec[AW-1:0];
               state_in    = ST_INS_EVAL;
            end
         end

         ST_INS_EVAL: begin
            mem_wr_en = 1'b1;
            if (mem_rd_data.priority_num > item_ff.priority_num) begin
               mem_wr_data = mem_rd_data;
               idx_in      = idx_dec;
               state_in    = ST_INS_STEP;
            end else begin
               count_in = count_ff + CW'(1);
               state_in = ST_HEAD_RD;
            end
         end

         // Search from the head; after a removal hit, close the gap.
         ST_SCAN_STEP: begin
            if (idx_ff >= count_ff) begin
               if (hit_ff) begin
                  count_in = count_ff - CW'(1);
               end
               state_in = ST_HEAD_RD;
            end else begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = idx_ff[AW-1:0];
               state_in    = ST_SCAN_EVAL;
            end
         end

         ST_SCAN_EVAL: begin
            idx_in   = idx_ff + CW'(1);
            state_in = ST_SCAN_STEP;
            if (hit_ff) begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = idx_dec[AW-1:0];
               mem_wr_data = mem_rd_data;
            end else if (mem_rd_data.pid == item_ff.pid) begin
               hit_in = 1'b1;
               if (mode_ff == MODE_REMOVE) begin
                  removed_in = mem_rd_data;
               end else begin
                  state_in = ST_HEAD_RD;
               end
            end
         end

         ST_HEAD_RD: begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = '0;
            state_in    = ST_HEAD_EVAL;
         end

         ST_HEAD_EVAL: begin
            head_in  = (count_ff == '0) ? '0 : mem_rd_data;
            state_in = ST_DONE;
         end

         ST_DONE: begin
            if (out_free) begin
               done     = 1'b1;
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

   always_comb begin
      result.found            = hit_ff;
      result.removed_pid      = removed_ff.pid;
      result.removed_priority = removed_ff.priority_num;
      result.overflow         = ovf_ff;
      result.queue_empty      = (count_ff == '0);
      result.head_pid         = head_ff.pid;
      result.head_priority    = head_ff.priority_num;
      result.fill_count       = 6'(count_ff);
   end

endmodule

// ===== verif/priority_ordered_process_queue_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Priority-ordered process queue testbench
// Drives insert, remove and lookup requests into the sorted queue. A
// scoreboard keeps its own sorted copy of the entries, predicts every
// response and compares each field of each response with the oldest
// prediction.
// ----------------------------------------------------------------------------

import popq_pkg::*;

class queue_scoreboard;
   logic [15:0] held_pid[$];
   logic [7:0]  held_prio[$];
   rsp_type     expected_rsp[$];
   int unsigned mismatches = 0;
   int unsigned depth;

   function new(int unsigned queue_depth);
      depth = queue_depth;
   endfunction

   function int find_pid(logic [15:0] pid);
      for (int i = 0; i < held_pid.size(); i++) begin
         if (held_pid[i] == pid) begin
            return i;
         end
      end
      return -1;
   endfunction

   // Applies one accepted request to the entry list and queues its response.
   function void note_request(req_type req);
      rsp_type exp;
      int      pos;
      exp = '0;
      case (req.mode)
         MODE_INSERT: begin
            if (held_pid.size() >= depth) begin
               exp.overflow = 1'b1;
            end else begin
               pos = 0;
               while (pos < held_prio.size() && held_prio[pos] <= req.item_priority) begin
                  pos++;
               end
               held_pid.insert(pos, req.item_pid);
               held_prio.insert(pos, req.item_priority);
            end
         end
         MODE_REMOVE: begin
            pos = find_pid(req.item_pid);
            if (pos >= 0) begin
               exp.found            = 1'b1;
               exp.removed_pid      = held_pid[pos];
               exp.removed_priority = held_prio[pos];
               held_pid.delete(pos);
               held_prio.delete(pos);
            end
         end
         MODE_LOOKUP: begin
            exp.found = (find_pid(req.item_pid) >= 0);
         end
         default: begin
         end
      endcase
      exp.queue_empty = (held_pid.size() == 0);
      if (held_pid.size() > 0) begin
         exp.head_pid      = held_pid[0];
         exp.head_priority = held_prio[0];
      end
      exp.fill_count = 6'(held_pid.size());
      expected_rsp.push_back(exp);
   endfunction

   function void check_response(rsp_type got);
      rsp_type exp;
      string   bad_fields;
      if (expected_rsp.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("[%0t] response with no request outstanding: %h", $realtime, got);
         end
         return;
      end
      exp = expected_rsp.pop_front();
      bad_fields = "";
      if (got.found !== exp.found) bad_fields = {bad_fields, " found"};
      if (got.removed_pid !== exp.removed_pid) bad_fields = {bad_fields, " removed_pid"};
      if (got.removed_priority !== exp.removed_priority) begin
         bad_fields = {bad_fields, " removed_priority"};
      end
      if (got.overflow !== exp.overflow) bad_fields = {bad_fields, " overflow"};
      if (got.queue_empty !== exp.queue_empty) bad_fields = {bad_fields, " queue_empty"};
      if (got.head_pid !== exp.head_pid) bad_fields = {bad_fields, " head_pid"};
      if (got.head_priority !== exp.head_priority) bad_fields = {bad_fields, " head_priority"};
      if (got.fill_count !== exp.fill_count) bad_fields = {bad_fields, " fill_count"};
      if (bad_fields != "") begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("[%0t] field mismatch:%s", $realtime, bad_fields);
            $display("   expected found=%b rm=%h/%h ovf=%b empty=%b head=%h/%h fill=%0d",
                     exp.found, exp.removed_pid, exp.removed_priority, exp.overflow,
                     exp.queue_empty, exp.head_pid, exp.head_priority, exp.fill_count);
            $display("   actual   found=%b rm=%h/%h ovf=%b empty=%b head=%h/%h fill=%0d",
                     got.found, got.removed_pid, got.removed_priority, got.overflow,
                     got.queue_empty, got.head_pid, got.head_priority, got.fill_count);
         end
      end
   endfunction
endclass

module priority_ordered_process_queue_top_tb;

   localparam int         QUEUE_DEPTH     = DEFAULT_QUEUE_DEPTH;
   // Mode 3 has no operation; the queue must leave its entries alone.
   localparam logic [1:0] MODE_UNUSED     = 2'd3;
   localparam int         RANDOM_REQUESTS = 2000;
   // A remove or lookup over a full queue is the slowest request. The tail
   // wait at the end allows for that plus some slack.
   localparam int         TAIL_CYCLES     = 2 * QUEUE_DEPTH + 40;
   localparam int         CYCLE_LIMIT     = 1_000_000;

   typedef enum int {PHASE_FILL, PHASE_DRAIN, PHASE_MIXED} phase_kind_type;
   typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_style_type;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   queue_scoreboard sb;
   int unsigned     cycle_count = 0;
   int unsigned     burst_left  = 0;
   stall_style_type stall_style = STALL_NONE;

   priority_ordered_process_queue_top #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // The watchdog ends a run that hangs. The limit sits far above the
   // slowest legal run: every request taking its longest scan, plus the
   // longest sender gaps and receiver stalls.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // Both channels are sampled at the rising edge. Inputs only move at the
   // falling edge, so what is seen here is exactly what the block saw.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            sb.note_request(req_data);
         end
         if (rsp_valid && !rsp_stall) begin
            sb.check_response(rsp_data);
         end
      end
   end

   // The receiver switches at random between four stall behaviors: no stalls
   // at all, sparse random stalls, mostly stalled, or a fixed periodic
   // pattern. This moves the response back-pressure across every phase of
   // the sequencer while a later request is already being worked on.
   always @(negedge clock) begin
      if (cycle_count % 150 == 0) begin
         stall_style = stall_style_type'($urandom_range(0, 3));
      end
      case (stall_style)
         STALL_NONE:     rsp_stall = 1'b0;
         STALL_LIGHT:    rsp_stall = ($urandom_range(0, 3) == 0);
         STALL_HEAVY:    rsp_stall = ($urandom_range(0, 9) < 7);
         default:        rsp_stall = ((cycle_count % 9) < 4);
      endcase
   end

   // Presents one request and holds it until the block takes it. The sender
   // works in bursts; at the end of each burst it drops valid for a random
   // gap, and sometimes goes straight on with no gap at all.
   task automatic issue_request(input logic [1:0] mode, input logic [15:0] pid,
                                input logic [7:0] prio);
      req_type     req;
      int unsigned gap;
      req.mode          = mode;
      req.item_pid      = pid;
      req.item_priority = prio;
      @(negedge clock);
      req_valid = 1'b1;
      req_data  = req;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            @(negedge clock);
            req_valid = 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end else begin
         burst_left--;
      end
   endtask

   // Stops sending and waits until every predicted response has arrived.
   task automatic wait_until_drained();
      @(negedge clock);
      req_valid = 1'b0;
      while (sb.expected_rsp.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // Ids come mostly from a pool of 16 values, half of them near zero and
   // half near all ones, so that removes and lookups hit often and
   // duplicates build up. The rest are fully random.
   function automatic logic [15:0] pick_pid();
      logic [15:0] small_id;
      small_id = 16'($urandom_range(0, 15));
      if ($urandom_range(0, 9) < 8) begin
         return small_id[0] ? ~small_id : small_id;
      end
      return 16'($urandom);
   endfunction

   // Many small priorities make ties, which check that equal priorities keep
   // their arrival order.
   function automatic logic [7:0] pick_prio();
      int unsigned roll;
      roll = $urandom_range(0, 9);
      if (roll < 4) return 8'($urandom_range(0, 3));
      if (roll == 4) return 8'hFF;
      return 8'($urandom_range(0, 255));
   endfunction

   // Picks the operation for one random request. Fill phases drive the
   // queue into overflow, drain phases empty it, mixed phases hover between.
   function automatic logic [1:0] pick_mode(input phase_kind_type kind);
      int unsigned roll;
      int unsigned insert_pct;
      int unsigned remove_pct;
      roll = $urandom_range(0, 99);
      case (kind)
         PHASE_FILL: begin
            insert_pct = 80;
            remove_pct = 10;
         end
         PHASE_DRAIN: begin
            insert_pct = 20;
            remove_pct = 60;
         end
         default: begin
            insert_pct = 45;
            remove_pct = 35;
         end
      endcase
      if (roll < insert_pct) return MODE_INSERT;
      if (roll < insert_pct + remove_pct) return MODE_REMOVE;
      if (roll < 98) return MODE_LOOKUP;
      return MODE_UNUSED;
   endfunction

   initial begin
      int unsigned    issued;
      int unsigned    phase_len;
      phase_kind_type kind;
      logic [1:0]     mode;
      logic [15:0]    pid;

      sb        = new(QUEUE_DEPTH);
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      repeat (3) @(negedge clock);
      reset = 1'b0;

      // Directed part. Requests on the empty queue come first, then a small
      // list with priority ties, a duplicate id and both extreme ids and
      // priorities, then removes that take the head, a middle entry, the
      // first of two duplicates and the tail, ending on an empty queue.
      issue_request(MODE_LOOKUP, 16'h0000, 8'h00);
      issue_request(MODE_REMOVE, 16'hFFFF, 8'hFF);
      issue_request(MODE_UNUSED, 16'h0000, 8'h00);
      issue_request(MODE_INSERT, 16'hFFFF, 8'hFF);
      issue_request(MODE_INSERT, 16'h0000, 8'h00);
      issue_request(MODE_INSERT, 16'h1234, 8'h00);
      issue_request(MODE_INSERT, 16'h1234, 8'h80);
      issue_request(MODE_INSERT, 16'h5A5A, 8'hFF);
      issue_request(MODE_INSERT, 16'hA5A5, 8'h5A);
      issue_request(MODE_LOOKUP, 16'h1234, 8'hFF);
      issue_request(MODE_LOOKUP, 16'h4321, 8'h00);
      issue_request(MODE_UNUSED, 16'hFFFF, 8'hFF);
      issue_request(MODE_REMOVE, 16'h1234, 8'h00);
      issue_request(MODE_REMOVE, 16'h1234, 8'h00);
      issue_request(MODE_REMOVE, 16'h0000, 8'h00);
      issue_request(MODE_REMOVE, 16'h9999, 8'h00);
      issue_request(MODE_REMOVE, 16'hA5A5, 8'h00);
      issue_request(MODE_REMOVE, 16'hFFFF, 8'h00);
      issue_request(MODE_LOOKUP, 16'h5A5A, 8'h00);
      issue_request(MODE_REMOVE, 16'h5A5A, 8'h00);
      issue_request(MODE_REMOVE, 16'h5A5A, 8'h00);
      wait_until_drained();

      // Random part, in phases. The first phase is a long fill so that the
      // queue reaches overflow early; later phases pick their kind at random.
      // Half the removes and lookups in a phase aim at an id that is held
      // right now, so that removes from every position in the list happen.
      issued = 0;
      kind   = PHASE_FILL;
      while (issued < RANDOM_REQUESTS) begin
         phase_len = (issued == 0) ? 60 : $urandom_range(40, 150);
         repeat (phase_len) begin
            mode = pick_mode(kind);
            pid  = pick_pid();
            if (mode != MODE_INSERT && sb.held_pid.size() > 0 && $urandom_range(0, 1) == 1) begin
               pid = sb.held_pid[$urandom_range(0, sb.held_pid.size() - 1)];
            end
            issue_request(mode, pid, pick_prio());
            issued++;
         end
         // Now and then the sender holds off until the block has answered
         // everything, so that requests also start on a fully idle block.
         if (issued == phase_len || $urandom_range(0, 2) == 0) begin
            wait_until_drained();
         end
         kind = phase_kind_type'($urandom_range(0, 2));
      end

      wait_until_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.mismatches == 0 && sb.expected_rsp.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
